/* src/assert_macros.svh */
// assertion helpers used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_IMPLY(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("implication check failed");

// next-cycle implication, disabled in reset
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("next-cycle check failed");

`endif

/* src/kmcu_pkg.sv */
`timescale 1ns / 1ps
package kmcu_pkg;

  localparam int SUM_W   = 48;
  localparam int COORD_W = 32;
  localparam int CFG_W   = 5;
  localparam int USE_W   = 7;

  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  localparam logic REG_CLUSTERS = 1'b0;
  localparam logic REG_DIMS     = 1'b1;

  localparam logic [3:0] CLUSTERS_RESET = 4'd8;
  localparam logic [4:0] DIMS_RESET     = 5'd16;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADD_WR,
    ST_FIN_RD,
    ST_FIN_LOAD,
    ST_FIN_DIV,
    ST_FIN_EMIT
  } state_t;

  typedef struct packed {
    logic                       operation;
    logic [2:0]                 cluster_index;
    logic [3:0]                 dimension_index;
    logic signed [COORD_W-1:0]  coordinate;
    logic                       point_done;
  } in_item_t;

  typedef struct packed {
    logic [2:0]                 out_cluster;
    logic [3:0]                 out_dimension;
    logic signed [COORD_W-1:0]  mean;
    logic                       cluster_empty;
    logic                       overflowed;
    logic                       last_result;
  } out_item_t;

  typedef struct packed {
    logic accept;
    logic clr_wr;
    logic add_wr;
    logic fin_rd;
    logic fin_load;
    logic div_go;
    logic emit;
    logic dim_next;
    logic fin_end;
  } cmd_t;

  typedef struct packed {
    logic item_ok;
    logic item_op;
    logic item_full;
    logic dim_ok;
    logic clr_last;
    logic div_done;
    logic dim_use;
    logic dim_last;
    logic cnt_zero;
  } status_t;

endpackage

/* src/kmcu_ram.sv */
`timescale 1ns / 1ps
module kmcu_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* src/kmcu_div.sv */
`timescale 1ns / 1ps
module kmcu_div #(
  parameter int DW = 48,
  parameter int VW = 17
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 go,
  input  logic signed [DW-1:0] dividend,
  input  logic [VW-1:0]        divisor,
  output logic                 done,
  output logic [DW-1:0]        quot,
  output logic                 neg
);

  localparam int STW = $clog2(DW);

  logic [DW-1:0]  a_r, a_nxt;
  logic [VW-1:0]  rem_r, rem_nxt;
  logic [VW-1:0]  b_r;
  logic [STW-1:0] step_r, step_nxt;
  logic           run_r, run_nxt;
  logic           done_r, done_nxt;
  logic           neg_r;
  logic [VW:0]    rem_sh;
  logic [VW:0]    diff;
  logic           ge;

  // restoring division, one quotient bit per cycle
  assign rem_sh = {rem_r, a_r[DW-1]};
  assign diff   = rem_sh - {1'b0, b_r};
  assign ge     = rem_sh >= {1'b0, b_r};

  always_comb begin
    a_nxt    = a_r;
    rem_nxt  = rem_r;
    step_nxt = step_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (go) begin
      a_nxt    = dividend[DW-1] ? (~dividend + DW'(1)) : dividend;
      rem_nxt  = '0;
      step_nxt = '0;
      run_nxt  = 1'b1;
    end else if (run_r) begin
      rem_nxt  = ge ? diff[VW-1:0] : rem_sh[VW-1:0];
      a_nxt    = {a_r[DW-2:0], ge};
      step_nxt = step_r + STW'(1);
      if (step_r == STW'(DW-1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    a_r   <= a_nxt;
    rem_r <= rem_nxt;
    if (go) begin
      b_r   <= divisor;
      neg_r <= dividend[DW-1];
    end
  end

  assign done = done_r;
  assign quot = a_r;
  assign neg  = neg_r;

endmodule

/* src/kmcu_ctrl.sv */
`timescale 1ns / 1ps
module kmcu_ctrl import kmcu_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  input  status_t status,
  output cmd_t    cmd,
  output logic    busy
);

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (status.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (start && status.item_ok) begin
          if (status.item_op == OP_FINISH) begin
            state_nxt = ST_FIN_RD;
          end else if (!status.item_full && status.dim_ok) begin
            state_nxt = ST_ADD_WR;
          end
        end
      end
      ST_ADD_WR: state_nxt = ST_IDLE;
      ST_FIN_RD: state_nxt = ST_FIN_LOAD;
      ST_FIN_LOAD: begin
        if (status.dim_use) begin
          state_nxt = status.cnt_zero ? ST_FIN_EMIT : ST_FIN_DIV;
        end else begin
          state_nxt = status.dim_last ? ST_IDLE : ST_FIN_RD;
        end
      end
      ST_FIN_DIV: begin
        if (status.div_done) state_nxt = ST_FIN_EMIT;
      end
      ST_FIN_EMIT: state_nxt = status.dim_last ? ST_IDLE : ST_FIN_RD;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state_r)
      ST_CLEAR: cmd.clr_wr = 1'b1;
      ST_IDLE: begin
        busy       = 1'b0;
        cmd.accept = start;
      end
      ST_ADD_WR: cmd.add_wr = 1'b1;
      ST_FIN_RD: cmd.fin_rd = 1'b1;
      ST_FIN_LOAD: begin
        cmd.fin_load = 1'b1;
        cmd.div_go   = status.dim_use && !status.cnt_zero;
        if (!status.dim_use) begin
          cmd.dim_next = !status.dim_last;
          cmd.fin_end  = status.dim_last;
        end
      end
      ST_FIN_DIV: ;
      ST_FIN_EMIT: begin
        cmd.emit     = 1'b1;
        cmd.dim_next = !status.dim_last;
        cmd.fin_end  = status.dim_last;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* src/kmcu_dp.sv */
`timescale 1ns / 1ps
module kmcu_dp import kmcu_pkg::*; #(
  parameter int MAX_CLUSTERS   = 8,
  parameter int MAX_DIMENSIONS = 16,
  parameter int MAX_POINTS     = 65536
) (
  input  logic             clk,
  input  logic             rst_n,
  input  in_item_t         in_item,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  cmd_t             cmd,
  output status_t          status,
  output logic             out_valid,
  output out_item_t        out_item
);

  localparam int N   = MAX_CLUSTERS * MAX_DIMENSIONS;
  localparam int AW  = (N > 1) ? $clog2(N) : 1;
  localparam int CW  = $clog2(MAX_POINTS + 1);
  localparam int CIW = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
  localparam int DCW = (MAX_DIMENSIONS > 1) ? $clog2(MAX_DIMENSIONS) : 1;

  logic [3:0]       cc_r;
  logic [4:0]       dc_r;
  logic [USE_W-1:0] cin, nd;

  in_item_t         item_r;
  logic [AW-1:0]    addr_r, clr_r;
  logic [DCW-1:0]   dim_r;
  logic [CW-1:0]    counts_r [MAX_CLUSTERS];
  logic             flags_r  [MAX_CLUSTERS];

  logic [CIW-1:0]   cidx_in, cidx_r;
  logic [CW-1:0]    count_in, cnt_fin;
  logic [AW-1:0]    addr_in, addr_fin, raddr, waddr;
  logic [SUM_W-1:0] rd_data, wdata, ext;
  logic             we, re, add_ok;

  logic             div_done, div_neg;
  logic [SUM_W-1:0] quot;
  logic [COORD_W-1:0] mean_sat;

  out_item_t        out_r;
  logic             out_valid_r;

  // out-of-range register values clamp into range
  always_comb begin
    if (cc_r == '0) cin = USE_W'(1);
    else if (USE_W'(cc_r) > USE_W'(MAX_CLUSTERS)) cin = USE_W'(MAX_CLUSTERS);
    else cin = USE_W'(cc_r);
    if (dc_r == '0) nd = USE_W'(1);
    else if (USE_W'(dc_r) > USE_W'(MAX_DIMENSIONS)) nd = USE_W'(MAX_DIMENSIONS);
    else nd = USE_W'(dc_r);
  end

  assign cidx_in  = CIW'(in_item.cluster_index);
  assign cidx_r   = CIW'(item_r.cluster_index);
  assign count_in = counts_r[cidx_in];
  assign cnt_fin  = counts_r[cidx_r];
  assign addr_in  = AW'(int'(in_item.cluster_index) * MAX_DIMENSIONS
                        + int'(in_item.dimension_index));
  assign addr_fin = AW'(int'(item_r.cluster_index) * MAX_DIMENSIONS + int'(dim_r));

  always_comb begin
    status           = '0;
    status.item_ok   = USE_W'(in_item.cluster_index) < cin;
    status.item_op   = in_item.operation;
    status.item_full = count_in >= CW'(MAX_POINTS);
    status.dim_ok    = USE_W'(in_item.dimension_index) < nd;
    status.clr_last  = clr_r == AW'(N - 1);
    status.div_done  = div_done;
    status.dim_use   = USE_W'(dim_r) < nd;
    status.dim_last  = dim_r == DCW'(MAX_DIMENSIONS - 1);
    status.cnt_zero  = cnt_fin == '0;
  end

  assign add_ok = cmd.accept && status.item_ok && (in_item.operation == OP_ADD)
                  && !status.item_full;

  assign re    = (add_ok && status.dim_ok) || cmd.fin_rd;
  assign raddr = cmd.accept ? addr_in : addr_fin;
  assign ext   = SUM_W'(item_r.coordinate);
  assign we    = cmd.clr_wr || cmd.add_wr || cmd.fin_load;
  assign waddr = cmd.clr_wr ? clr_r : addr_r;
  assign wdata = cmd.add_wr ? (rd_data + ext) : '0;

  kmcu_ram #(.WIDTH(SUM_W), .DEPTH(N), .AW(AW)) u_sums (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rd_data)
  );

  kmcu_div #(.DW(SUM_W), .VW(CW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (cmd.div_go),
    .dividend (rd_data),
    .divisor  (cnt_fin),
    .done     (div_done),
    .quot     (quot),
    .neg      (div_neg)
  );

  // saturate the quotient magnitude into signed 32 bits
  always_comb begin
    if (div_neg) begin
      if (quot > 48'h0000_8000_0000) mean_sat = 32'h8000_0000;
      else mean_sat = ~quot[31:0] + 32'd1;
    end else begin
      if (quot > 48'h0000_7FFF_FFFF) mean_sat = 32'h7FFF_FFFF;
      else mean_sat = quot[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cc_r        <= CLUSTERS_RESET;
      dc_r        <= DIMS_RESET;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < MAX_CLUSTERS; i++) begin
        counts_r[i] <= '0;
        flags_r[i]  <= 1'b0;
      end
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_CLUSTERS) cc_r <= cfg_data[3:0];
        else dc_r <= cfg_data;
      end
      if (cmd.clr_wr) clr_r <= clr_r + AW'(1);
      out_valid_r <= cmd.emit;
      if (cmd.accept && status.item_ok && (in_item.operation == OP_ADD)) begin
        if (status.item_full) flags_r[cidx_in] <= 1'b1;
        else if (in_item.point_done) counts_r[cidx_in] <= count_in + CW'(1);
      end
      if (cmd.fin_end) begin
        counts_r[cidx_r] <= '0;
        flags_r[cidx_r]  <= 1'b0;
      end
    end
    if (cmd.accept) begin
      item_r <= in_item;
      addr_r <= addr_in;
      dim_r  <= '0;
    end
    if (cmd.fin_rd) addr_r <= addr_fin;
    if (cmd.dim_next) dim_r <= dim_r + DCW'(1);
    if (cmd.emit) begin
      out_r.out_cluster   <= item_r.cluster_index;
      out_r.out_dimension <= 4'(dim_r);
      out_r.mean          <= status.cnt_zero ? '0 : mean_sat;
      out_r.cluster_empty <= status.cnt_zero;
      out_r.overflowed    <= flags_r[cidx_r];
      out_r.last_result   <= USE_W'(dim_r) == (nd - USE_W'(1));
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

/* src/kmeans_centroid_mean_update_core.sv */
`timescale 1ns / 1ps
// channel  | ports                          | transfer
// input    | start, busy, in_item           | start high while busy low
// result   | out_valid, out_item            | each cycle out_valid is high
// config   | cfg_we, cfg_index, cfg_data    | each cycle cfg_we is high
//
// add item: a read then a write of the sum memory; no write if its cluster is
// not in use, the cluster is full or the dimension is unused.
// finish item: after the accept, each used dimension slot passes through read, load,
// the 48-step serial divider and emit; an empty cluster skips the divider and an unused
// slot ends after the load; all MAX_DIMENSIONS slots are cleared.
// after reset a clearing pass over all MAX_CLUSTERS*MAX_DIMENSIONS sum entries holds busy.
// results cannot be stalled; each is shown for one cycle.
module kmeans_centroid_mean_update_core import kmcu_pkg::*; #(
  parameter int MAX_CLUSTERS   = 8,
  parameter int MAX_DIMENSIONS = 16,
  parameter int MAX_POINTS     = 65536
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  in_item_t         in_item,
  output logic             out_valid,
  output out_item_t        out_item,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  cmd_t    cmd;
  status_t status;

  kmcu_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  kmcu_dp #(
    .MAX_CLUSTERS   (MAX_CLUSTERS),
    .MAX_DIMENSIONS (MAX_DIMENSIONS),
    .MAX_POINTS     (MAX_POINTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

/* src/kmcu_checker.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
module kmcu_checker import kmcu_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input logic      out_valid,
  input out_item_t out_item
);

  // results of one finish are never back to back
  `ASSERT_NEXT(a_strobe_gap, clk, rst_n, out_valid, !out_valid)
  // a finish stays busy until its final result
  `ASSERT_IMPLY(a_busy_mid, clk, rst_n, out_valid && !out_item.last_result, busy)
  // a freshly taken item cannot produce a result at once
  `ASSERT_NEXT(a_accept_quiet, clk, rst_n, start && !busy, !out_valid)
  // an empty cluster reports a zero mean
  `ASSERT_IMPLY(a_empty_zero, clk, rst_n, out_valid && out_item.cluster_empty,
                out_item.mean == '0)

endmodule

bind kmeans_centroid_mean_update_core kmcu_checker u_chk (.*);
